[hw/rtl/rpn_pkg.sv]
// Shared types and constants for the postfix stack evaluator.
`default_nettype none

package rpn_pkg;

    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 7;
    localparam int REQ_W   = 3;
    localparam int STEP_W  = 5;   // counts the 32 steps of multiply and divide

    localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SUB  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MUL  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DIV  = 3'd4;

    localparam logic [STEP_W-1:0] LAST_STEP = 5'd31;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_DIVZERO   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic              start;
        t_alu_op           op;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_alu_rsp;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] operand_value;
        logic                     last_token;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       stack_depth;
        t_status                  status;
        logic                     expression_done;
    } t_out_beat;

endpackage

`default_nettype wire

[hw/rtl/rpn_stack_evaluator.sv]
// Top level of the postfix integer expression evaluator.
//
//  Channel | Direction | Handshake                  | Beat
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall    | t_in_beat: token type, value, last
//  out     | output    | o_out_valid / i_out_stall  | t_out_beat: top, depth, status, done
//
// One token at a time. From input accept to result valid, push, unused codes
// and underflow go through S_FETCH and S_DONE; operators also go through
// S_EXEC and S_WAIT (a divide by zero skips S_WAIT). The next token can be
// accepted in the cycle after the result is loaded. Multiply and divide run 32
// steps on the shared adder in rpn_alu; the first operand is the registered RAM read.
// Reset (i_rst_n low, synchronous) empties the stack; the RAM is not cleared.
// A result held by i_out_stall keeps the block in its final state; a new
// token is not taken until that result moves into the output register.
`default_nettype none

module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rpn_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rpn_pkg::t_out_beat o_out_beat
);
    import rpn_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_EXEC  = 5'b00100,
        S_WAIT  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state;
    t_in_beat           r_in;
    t_status            r_status;
    logic [SP_W-1:0]    r_sp;       // entry count, top lives in r_tos
    logic [DATA_W-1:0]  r_tos;
    logic [DATA_W-1:0]  r_mem [STACK_DEPTH];   // entries below the top
    logic [DATA_W-1:0]  r_rd_data;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic               in_acc;
    logic               out_free;
    logic               is_push;
    logic               is_op;
    logic               full;
    logic               divzero;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_push  = (r_in.req_type == REQ_PUSH);
    assign is_op    = (r_in.req_type == REQ_ADD) || (r_in.req_type == REQ_SUB) ||
                      (r_in.req_type == REQ_MUL) || (r_in.req_type == REQ_DIV);
    assign full     = (r_sp == SP_W'(STACK_DEPTH));
    assign divzero  = (r_in.req_type == REQ_DIV) && (r_tos == '0);

    // push spills the old top into RAM; the entry below the top sits at count-2
    assign wr_addr  = AW'(r_sp - 1'b1);
    assign rd_addr  = AW'(r_sp - 2'd2);
    assign mem_we   = (r_state == S_FETCH) && is_push && !full && (r_sp != '0);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_tos;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        alu_req.start = (r_state == S_EXEC) && !divzero;
        unique case (r_in.req_type)
            REQ_SUB: alu_req.op = ALU_SUB;
            REQ_MUL: alu_req.op = ALU_MUL;
            REQ_DIV: alu_req.op = ALU_DIV;
            default: alu_req.op = ALU_ADD;
        endcase
    end

    rpn_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (r_rd_data),
        .i_b     (r_tos),
        .o_rsp   (alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE either reloads the output register or holds it stalled
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_in    <= i_in_beat;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    if (is_push) begin
                        r_state <= S_DONE;
                        if (full) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_OK;
                            r_tos    <= r_in.operand_value;
                            r_sp     <= r_sp + 1'b1;
                        end
                    end else if (is_op) begin
                        if (r_sp < SP_W'(2)) begin
                            r_status <= ST_UNDERFLOW;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_EXEC;   // RAM read lands next cycle
                        end
                    end else begin
                        r_status <= ST_OK;
                        r_state  <= S_DONE;
                    end
                end
                S_EXEC: begin
                    if (divzero) begin
                        r_status <= ST_DIVZERO;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        r_tos   <= alu_rsp.result;
                        r_sp    <= r_sp - 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid                 <= 1'b1;
                        r_out.top_value             <= (r_sp != '0) ? r_tos : '0;
                        r_out.stack_depth           <= DEPTH_W'(r_sp);
                        r_out.status                <= r_status;
                        r_out.expression_done       <= r_in.last_token;
                        if (r_in.last_token) begin
                            r_sp <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire

[hw/rtl/rpn_alu.sv]
// Shared arithmetic unit: one 33-bit adder for add, subtract, shift-add multiply, signed divide.
`default_nettype none

module rpn_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpn_pkg::t_alu_req  i_req,
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    output rpn_pkg::t_alu_rsp  o_rsp
);
    import rpn_pkg::*;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_FIX  = 4'b1000
    } t_astate;

    t_astate             r_state;
    logic                r_done;
    logic [DATA_W-1:0]   r_res;
    logic [DATA_W-1:0]   r_acc;
    logic [DATA_W-1:0]   r_x;     // multiplicand, or dividend/quotient shifter
    logic [DATA_W-1:0]   r_y;     // multiplier, or divisor magnitude
    logic [DATA_W-1:0]   r_rem;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_neg;

    logic [DATA_W-1:0]   opa;
    logic [DATA_W-1:0]   opb;
    logic                sub;
    logic [DATA_W:0]     sum;
    logic [DATA_W-1:0]   div_part;
    logic [DATA_W-1:0]   a_abs;
    logic [DATA_W-1:0]   b_abs;

    assign div_part = {r_rem[DATA_W-2:0], r_x[DATA_W-1]};
    assign a_abs    = i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
    assign b_abs    = i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;

    // operand select for the single adder
    always_comb begin
        opa = i_a;
        opb = i_b;
        sub = (i_req.op == ALU_SUB);
        unique case (r_state)
            A_IDLE: begin
                opa = i_a;
                opb = i_b;
                sub = (i_req.op == ALU_SUB);
            end
            A_MUL: begin
                opa = r_acc;
                opb = r_x;
                sub = 1'b0;
            end
            A_DIV: begin
                opa = div_part;
                opb = r_y;
                sub = 1'b1;
            end
            A_FIX: begin
                opa = '0;
                opb = r_x;
                sub = 1'b1;
            end
            default: begin
                opa = i_a;
                opb = i_b;
                sub = 1'b0;
            end
        endcase
    end

    // carry out on subtract means no borrow
    assign sum = {1'b0, opa} + {1'b0, opb ^ {DATA_W{sub}}} + {{DATA_W{1'b0}}, sub};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                A_IDLE: begin
                    r_done <= i_req.start &&
                              ((i_req.op == ALU_ADD) || (i_req.op == ALU_SUB));
                    if (i_req.start) begin
                        unique case (i_req.op)
                            ALU_ADD, ALU_SUB: begin
                                r_res  <= sum[DATA_W-1:0];
                            end
                            ALU_MUL: begin
                                r_acc   <= '0;
                                r_x     <= i_a;
                                r_y     <= i_b;
                                r_cnt   <= '0;
                                r_state <= A_MUL;
                            end
                            ALU_DIV: begin
                                r_rem   <= '0;
                                r_x     <= a_abs;
                                r_y     <= b_abs;
                                r_neg   <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
                                r_cnt   <= '0;
                                r_state <= A_DIV;
                            end
                            default: r_state <= A_IDLE;
                        endcase
                    end
                end
                A_MUL: begin
                    if (r_y[0]) begin
                        r_acc <= sum[DATA_W-1:0];
                    end
                    r_x    <= {r_x[DATA_W-2:0], 1'b0};
                    r_y    <= {1'b0, r_y[DATA_W-1:1]};
                    r_cnt  <= r_cnt + 1'b1;
                    r_done <= (r_cnt == LAST_STEP);
                    if (r_cnt == LAST_STEP) begin
                        r_res   <= r_y[0] ? sum[DATA_W-1:0] : r_acc;
                        r_state <= A_IDLE;
                    end
                end
                A_DIV: begin
                    r_done <= 1'b0;
                    r_rem  <= sum[DATA_W] ? sum[DATA_W-1:0] : div_part;
                    r_x    <= {r_x[DATA_W-2:0], sum[DATA_W]};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    // quotient sign; magnitude 2^31 with equal signs wraps to INT_MIN
                    r_res   <= r_neg ? sum[DATA_W-1:0] : r_x;
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

`default_nettype wire

[hw/rtl/rpn_chk.sv]
// Port-level checks for the postfix evaluator, bound to the top level.
`default_nettype none

module rpn_chk #(
    parameter int STACK_DEPTH = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rpn_pkg::t_out_beat o_out_beat
);
    import rpn_pkg::*;

    localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(STACK_DEPTH);

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    // one token at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous token still in work");

    a_underflow_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status == ST_UNDERFLOW) |->
            (o_out_beat.stack_depth < DEPTH_W'(2)))
        else $error("underflow reported with two or more entries");

    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status == ST_FULL) |->
            (o_out_beat.stack_depth == FULL_DEPTH))
        else $error("stack full reported below capacity");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.stack_depth == '0) && (STACK_DEPTH < 128) |->
            (o_out_beat.top_value == '0))
        else $error("empty stack shows nonzero top");

endmodule

bind rpn_stack_evaluator rpn_chk #(
    .STACK_DEPTH (STACK_DEPTH)
) u_rpn_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire
